// ----- rtl/lcadc_pkg.sv -----
package lcadc_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SUM_W       = 32;
  localparam int DIV_CNT_W   = $clog2(SUM_W);
  localparam int REM_W       = 8;

  localparam logic [4:0] PULSES_GAIN_128 = 5'd25;
  localparam logic [4:0] PULSES_GAIN_64  = 5'd27;
  localparam logic [4:0] PULSES_GAIN_32  = 5'd26;

  localparam logic [1:0] GAIN_A_64 = 2'd1;
  localparam logic [1:0] GAIN_B_32 = 2'd2;

  localparam logic [2:0] REG_GAIN_MODE     = 3'd0;
  localparam logic [2:0] REG_FAST_RATE     = 3'd1;
  localparam logic [2:0] REG_AVERAGE_COUNT = 3'd2;
  localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd3;
  localparam logic [2:0] REG_HALF_PERIOD   = 3'd4;
  localparam logic [2:0] REG_SHIFT_A       = 3'd5;
  localparam logic [2:0] REG_SHIFT_B       = 3'd6;

  localparam logic [7:0]  AVERAGE_RESET     = 8'd1;
  localparam logic [23:0] TIMEOUT_RESET     = 24'd100000;
  localparam logic [7:0]  HALF_PERIOD_RESET = 8'd2;

  typedef struct packed {
    logic cmd;
    logic data_level;
  } in_item_t;

  typedef struct packed {
    logic               clock_level;
    logic               rate_level;
    logic               busy_res;
    logic               done_res;
    logic               timed_out;
    logic signed [23:0] value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  gain_mode;
    logic        fast_rate;
    logic [7:0]  average_count;
    logic [23:0] timeout_ticks;
    logic [7:0]  half_period_ticks;
    logic [4:0]  shift_channel_a;
    logic [4:0]  shift_channel_b;
  } cfg_t;

  typedef struct packed {
    logic clear_all;
    logic hp_step;
    logic pulse_step;
    logic shift_in;
    logic wait_clr;
    logic wait_step;
    logic rd_start;
    logic accumulate;
    logic sum_clr;
    logic div_start;
  } ctl_cmd_t;

  typedef struct packed {
    logic half_done;
    logic pulse_last;
    logic sample_last;
    logic wait_expired;
    logic bit_in_range;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic load;
    logic clock_level;
    logic busy;
    logic done;
    logic tmo;
    logic use_quot;
  } res_ctl_t;

endpackage

// ----- rtl/lcadc_ctrl.sv -----
module lcadc_ctrl
  import lcadc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  in_item_t in_item,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output res_ctl_t res,
  output logic     dividing
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PRE_HI = 7'b0000010,
    ST_PRE_LO = 7'b0000100,
    ST_WAIT   = 7'b0001000,
    ST_RD_HI  = 7'b0010000,
    ST_RD_LO  = 7'b0100000,
    ST_DIVIDE = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign dividing = (state == ST_DIVIDE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    res        = '0;
    if (in_fire) begin
      unique case (state)
        ST_IDLE: begin
          if (in_item.cmd) begin
            cmd.clear_all = 1'b1;
            state_next    = ST_PRE_HI;
          end
        end
        ST_PRE_HI: begin
          cmd.hp_step = 1'b1;
          if (stat.half_done) state_next = ST_PRE_LO;
        end
        ST_PRE_LO: begin
          cmd.hp_step = 1'b1;
          if (stat.half_done) begin
            cmd.pulse_step = 1'b1;
            if (stat.pulse_last) begin
              cmd.wait_clr = 1'b1;
              state_next   = ST_WAIT;
            end else begin
              state_next = ST_PRE_HI;
            end
          end
        end
        ST_WAIT: begin
          if (!in_item.data_level) begin
            cmd.rd_start = 1'b1;
            state_next   = ST_RD_HI;
          end else begin
            cmd.wait_step = 1'b1;
            if (stat.wait_expired) begin
              cmd.sum_clr = 1'b1;
              res.done    = 1'b1;
              res.tmo     = 1'b1;
              state_next  = ST_IDLE;
            end
          end
        end
        ST_RD_HI: begin
          cmd.hp_step = 1'b1;
          if (stat.half_done) begin
            cmd.shift_in = stat.bit_in_range;
            state_next   = ST_RD_LO;
          end
        end
        ST_RD_LO: begin
          cmd.hp_step = 1'b1;
          if (stat.half_done) begin
            cmd.pulse_step = 1'b1;
            if (stat.pulse_last) begin
              cmd.accumulate = 1'b1;
              if (stat.sample_last) begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVIDE;
              end else begin
                cmd.wait_clr = 1'b1;
                state_next   = ST_WAIT;
              end
            end else begin
              state_next = ST_RD_HI;
            end
          end
        end
        ST_DIVIDE: begin
          state_next = ST_DIVIDE;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
      // final beat waits for the quotient
      if (state_next != ST_DIVIDE) begin
        res.load        = 1'b1;
        res.clock_level = (state_next == ST_PRE_HI) || (state_next == ST_RD_HI);
        res.busy        = (state_next != ST_IDLE);
      end
    end else if (dividing && stat.div_done) begin
      state_next   = ST_IDLE;
      res.load     = 1'b1;
      res.done     = 1'b1;
      res.use_quot = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/lcadc_dp.sv -----
module lcadc_dp
  import lcadc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               data_level,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  output logic signed [23:0] quotient
);

  logic [7:0]              hp_cnt;
  logic [4:0]              pulse_cnt;
  logic [SAMPLE_BITS-1:0]  shifter;
  logic [7:0]              sample_cnt;
  logic signed [SUM_W-1:0] sum;
  logic [23:0]             wait_cnt;

  logic [SUM_W-1:0]        quo;
  logic [REM_W-1:0]        rem;
  logic [7:0]              divisor;
  logic [DIV_CNT_W-1:0]    div_cnt;
  logic                    div_run;
  logic                    div_fin;
  logic                    neg;

  logic [7:0]              hp_limit, hp_inc;
  logic [4:0]              pulse_total, pulse_inc, shift_amt;
  logic [7:0]              avg_limit, sample_inc;
  logic [23:0]             to_limit, wait_inc;
  logic signed [SUM_W-1:0] decoded, sum_new;
  logic [SUM_W-1:0]        sum_mag, quo_signed;
  logic [REM_W:0]          trial, diff;
  logic                    ge;

  always_comb begin
    hp_limit   = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
    avg_limit  = (cfg.average_count == 8'd0) ? 8'd1 : cfg.average_count;
    to_limit   = (cfg.timeout_ticks == 24'd0) ? 24'd1 : cfg.timeout_ticks;
    hp_inc     = hp_cnt + 8'd1;
    pulse_inc  = pulse_cnt + 5'd1;
    sample_inc = sample_cnt + 8'd1;
    wait_inc   = wait_cnt + 24'd1;
    if (cfg.gain_mode == GAIN_A_64) begin
      pulse_total = PULSES_GAIN_64;
      shift_amt   = cfg.shift_channel_b;
    end else if (cfg.gain_mode == GAIN_B_32) begin
      pulse_total = PULSES_GAIN_32;
      shift_amt   = cfg.shift_channel_a;
    end else begin
      pulse_total = PULSES_GAIN_128;
      shift_amt   = cfg.shift_channel_a;
    end
    decoded = $signed({{(SUM_W-SAMPLE_BITS){shifter[SAMPLE_BITS-1]}}, shifter}) >>> shift_amt;
    sum_new = sum + decoded;
    sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

    trial = {rem, quo[SUM_W-1]};
    ge    = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};

    quo_signed = neg ? SUM_W'(-quo) : quo;
    quotient   = $signed(quo_signed[23:0]);

    stat.half_done    = (hp_inc >= hp_limit);
    stat.pulse_last   = (pulse_inc >= pulse_total);
    stat.sample_last  = (sample_inc >= avg_limit);
    stat.wait_expired = (wait_inc >= to_limit);
    stat.bit_in_range = (pulse_cnt < 5'(SAMPLE_BITS));
    stat.div_done     = div_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_cnt     <= '0;
      pulse_cnt  <= '0;
      shifter    <= '0;
      sample_cnt <= '0;
      sum        <= '0;
      wait_cnt   <= '0;
    end else if (cmd.clear_all) begin
      hp_cnt     <= '0;
      pulse_cnt  <= '0;
      shifter    <= '0;
      sample_cnt <= '0;
      sum        <= '0;
      wait_cnt   <= '0;
    end else begin
      if (cmd.rd_start) begin
        hp_cnt    <= '0;
        pulse_cnt <= '0;
        shifter   <= '0;
      end else begin
        if (cmd.hp_step) hp_cnt <= stat.half_done ? 8'd0 : hp_inc;
        if (cmd.pulse_step) pulse_cnt <= stat.pulse_last ? 5'd0 : pulse_inc;
        if (cmd.accumulate) begin
          shifter <= '0;
        end else if (cmd.shift_in) begin
          shifter <= {shifter[SAMPLE_BITS-2:0], data_level};
        end
      end
      if (cmd.accumulate) begin
        sample_cnt <= sample_inc;
        sum        <= sum_new;
      end else if (cmd.sum_clr) begin
        sum <= '0;
      end
      if (cmd.wait_clr) begin
        wait_cnt <= '0;
      end else if (cmd.wait_step) begin
        wait_cnt <= wait_inc;
      end
    end
  end

  // restoring divide of the sum magnitude, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      div_fin <= 1'b0;
      div_cnt <= '0;
    end else begin
      div_fin <= 1'b0;
      if (cmd.div_start) begin
        div_run <= 1'b1;
        div_cnt <= DIV_CNT_W'(SUM_W - 1);
      end else if (div_run) begin
        if (div_cnt == '0) begin
          div_run <= 1'b0;
          div_fin <= 1'b1;
        end else begin
          div_cnt <= div_cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg     <= sum_new[SUM_W-1];
      quo     <= sum_mag;
      rem     <= '0;
      divisor <= avg_limit;
    end else if (div_run) begin
      rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/load_cell_adc_serial_reader.sv -----
// Serial reader for a 24-bit load-cell converter. Each input beat is one timebase
// tick or a start command together with the sampled data pin, and each beat gives
// exactly one output beat with the serial clock and rate pin levels, busy, and,
// when a measurement ends, done, timed_out and the averaged reading. The beat that
// ends a successful measurement waits for a 32-step restoring divider (one quotient
// bit per cycle), and no input is taken until its output has been loaded.
// Configuration registers are written through the cfg port at any time, one per
// cycle, and take effect on the next beat.
module load_cell_adc_serial_reader
  import lcadc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t     cfg;
  ctl_cmd_t cmd;
  dp_stat_t stat;
  res_ctl_t res;
  logic     dividing;
  logic     in_fire;
  logic signed [23:0] quotient;

  assign cfg_ready = 1'b1;
  assign in_ready  = !dividing && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_mode         <= '0;
      cfg.fast_rate         <= 1'b0;
      cfg.average_count     <= AVERAGE_RESET;
      cfg.timeout_ticks     <= TIMEOUT_RESET;
      cfg.half_period_ticks <= HALF_PERIOD_RESET;
      cfg.shift_channel_a   <= '0;
      cfg.shift_channel_b   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_MODE:     cfg.gain_mode         <= cfg_data[1:0];
        REG_FAST_RATE:     cfg.fast_rate         <= cfg_data[0];
        REG_AVERAGE_COUNT: cfg.average_count     <= cfg_data[7:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks     <= cfg_data;
        REG_HALF_PERIOD:   cfg.half_period_ticks <= cfg_data[7:0];
        REG_SHIFT_A:       cfg.shift_channel_a   <= cfg_data[4:0];
        REG_SHIFT_B:       cfg.shift_channel_b   <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  lcadc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .stat     (stat),
    .cmd      (cmd),
    .res      (res),
    .dividing (dividing)
  );

  lcadc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .data_level (in_data.data_level),
    .cmd        (cmd),
    .stat       (stat),
    .quotient   (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data.clock_level <= res.clock_level;
      out_data.rate_level  <= res.busy & cfg.fast_rate;
      out_data.busy_res    <= res.busy;
      out_data.done_res    <= res.done;
      out_data.timed_out   <= res.tmo;
      out_data.value       <= res.use_quot ? quotient : 24'sd0;
    end
  end

  // a result may only land in an empty or draining output register
  assert property (@(posedge clk) disable iff (rst)
    res.load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending beat");

  // the divider finish must be picked up at once
  assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (dividing && res.load && res.use_quot))
    else $error("divider result dropped");

  // a timeout ends the measurement with a zero reading
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.timed_out) |->
      (out_data.done_res && !out_data.busy_res && out_data.value == 24'sd0))
    else $error("bad timeout beat");

endmodule

// ----- dv/lcadc_reading_checker.sv -----
module lcadc_reading_checker
  import lcadc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          mismatches,
  output int          results_due,
  output logic        measuring
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE_HIGH,
    ST_PRE_LOW,
    ST_WAIT_READY,
    ST_READ_HIGH,
    ST_READ_LOW
  } reader_state_t;

  cfg_t               regs;
  reader_state_t      state;
  logic [4:0]         pulse_cnt;
  logic [7:0]         half_cnt;
  logic [23:0]        shift_reg;
  logic [7:0]         sample_cnt;
  logic signed [31:0] sum_acc;
  logic [23:0]        wait_cnt;
  out_item_t          readings_due[$];
  int                 bad_fields = 0;

  assign mismatches = bad_fields;

  function automatic logic [4:0] frame_pulses(input logic [1:0] mode);
    case (mode)
      GAIN_A_64: return PULSES_GAIN_64;
      GAIN_B_32: return PULSES_GAIN_32;
      default:   return PULSES_GAIN_128;
    endcase
  endfunction

  function automatic logic signed [31:0] scaled_sample(input logic [23:0] raw,
                                                       input logic [4:0] sh);
    logic signed [31:0] wide;
    wide = {{8{raw[23]}}, raw};
    return wide >>> sh;
  endfunction

  // bumps the half period count, true on the last tick of the half period
  function automatic logic half_period_over();
    logic [7:0] span;
    span = (regs.half_period_ticks == 8'd0) ? 8'd1 : regs.half_period_ticks;
    half_cnt = half_cnt + 8'd1;
    if (half_cnt >= span) begin
      half_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_reader(input in_item_t beat, output out_item_t res);
    logic               done;
    logic               tmo;
    logic signed [31:0] avg;
    logic signed [31:0] divisor;
    logic [7:0]         count;
    logic [23:0]        limit;
    done = 1'b0;
    tmo = 1'b0;
    avg = '0;
    count = (regs.average_count == 8'd0) ? 8'd1 : regs.average_count;
    limit = (regs.timeout_ticks == 24'd0) ? 24'd1 : regs.timeout_ticks;
    case (state)
      ST_IDLE: begin
        if (beat.cmd) begin
          state = ST_PRE_HIGH;
          pulse_cnt = '0;
          half_cnt = '0;
          shift_reg = '0;
          sample_cnt = '0;
          sum_acc = '0;
          wait_cnt = '0;
        end
      end
      ST_PRE_HIGH: begin
        if (half_period_over()) state = ST_PRE_LOW;
      end
      ST_PRE_LOW: begin
        if (half_period_over()) begin
          pulse_cnt = pulse_cnt + 5'd1;
          if (pulse_cnt >= frame_pulses(regs.gain_mode)) begin
            pulse_cnt = '0;
            wait_cnt = '0;
            state = ST_WAIT_READY;
          end else begin
            state = ST_PRE_HIGH;
          end
        end
      end
      ST_WAIT_READY: begin
        if (!beat.data_level) begin
          state = ST_READ_HIGH;
          pulse_cnt = '0;
          half_cnt = '0;
          shift_reg = '0;
        end else begin
          wait_cnt = wait_cnt + 24'd1;
          if (wait_cnt >= limit) begin
            done = 1'b1;
            tmo = 1'b1;
            state = ST_IDLE;
            sum_acc = '0;
          end
        end
      end
      ST_READ_HIGH: begin
        if (half_period_over()) begin
          // pulses past the 24th only pick the next gain, no data
          if (pulse_cnt < SAMPLE_BITS) shift_reg = {shift_reg[22:0], beat.data_level};
          state = ST_READ_LOW;
        end
      end
      ST_READ_LOW: begin
        if (half_period_over()) begin
          pulse_cnt = pulse_cnt + 5'd1;
          if (pulse_cnt >= frame_pulses(regs.gain_mode)) begin
            sum_acc = sum_acc + scaled_sample(shift_reg, (regs.gain_mode == GAIN_A_64) ?
                                              regs.shift_channel_b : regs.shift_channel_a);
            sample_cnt = sample_cnt + 8'd1;
            pulse_cnt = '0;
            shift_reg = '0;
            if (sample_cnt >= count) begin
              divisor = {24'd0, count};
              avg = sum_acc / divisor;
              done = 1'b1;
              state = ST_IDLE;
            end else begin
              wait_cnt = '0;
              state = ST_WAIT_READY;
            end
          end else begin
            state = ST_READ_HIGH;
          end
        end
      end
      default: state = ST_IDLE;
    endcase
    res.clock_level = (state == ST_PRE_HIGH) || (state == ST_READ_HIGH);
    res.rate_level  = (state != ST_IDLE) && regs.fast_rate;
    res.busy_res    = (state != ST_IDLE);
    res.done_res    = done;
    res.timed_out   = tmo;
    res.value       = avg[23:0];
  endtask

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (rst) begin
      regs.gain_mode         = '0;
      regs.fast_rate         = 1'b0;
      regs.average_count     = AVERAGE_RESET;
      regs.timeout_ticks     = TIMEOUT_RESET;
      regs.half_period_ticks = HALF_PERIOD_RESET;
      regs.shift_channel_a   = '0;
      regs.shift_channel_b   = '0;
      state = ST_IDLE;
      pulse_cnt = '0;
      half_cnt = '0;
      shift_reg = '0;
      sample_cnt = '0;
      sum_acc = '0;
      wait_cnt = '0;
      readings_due.delete();
    end else begin
      // retire the output beat first, a beat taken this edge cannot be out yet
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          $error("output beat with no reading due");
          bad_fields++;
        end else begin
          want = readings_due.pop_front();
          compare_field("clock_level", 24'(want.clock_level), 24'(out_data.clock_level));
          compare_field("rate_level", 24'(want.rate_level), 24'(out_data.rate_level));
          compare_field("busy_res", 24'(want.busy_res), 24'(out_data.busy_res));
          compare_field("done_res", 24'(want.done_res), 24'(out_data.done_res));
          compare_field("timed_out", 24'(want.timed_out), 24'(out_data.timed_out));
          compare_field("value", want.value, out_data.value);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_MODE:     regs.gain_mode = cfg_data[1:0];
          REG_FAST_RATE:     regs.fast_rate = cfg_data[0];
          REG_AVERAGE_COUNT: regs.average_count = cfg_data[7:0];
          REG_TIMEOUT_TICKS: regs.timeout_ticks = cfg_data;
          REG_HALF_PERIOD:   regs.half_period_ticks = cfg_data[7:0];
          REG_SHIFT_A:       regs.shift_channel_a = cfg_data[4:0];
          REG_SHIFT_B:       regs.shift_channel_b = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_reader(in_data, fresh);
        readings_due.push_back(fresh);
      end
    end
    results_due <= readings_due.size();
    measuring <= (state != ST_IDLE);
  end

endmodule

// ----- dv/load_cell_adc_serial_reader_test.sv -----
module load_cell_adc_serial_reader_test;
  import lcadc_pkg::*;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam logic [1:0] GAIN_A_128  = 2'd0;
  localparam logic [1:0] GAIN_UNUSED = 2'd3;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEM_BUDGET  = 1550;
  // starts sent this early in a measurement always land inside the preamble
  localparam int BUSY_START_WINDOW = 40;

  typedef enum logic [1:0] {PIN_COIN, PIN_MOSTLY_HIGH, PIN_RUNS, PIN_HELD_LOW} pin_style_t;
  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_GAIN_MODE;
  logic [23:0] cfg_data = '0;

  int          mismatches;
  int          results_due;
  logic        measuring;

  int          beats_sent = 0;
  int          burst_left = 0;
  int          quiet_cycles = 0;
  rx_pattern_t rx_pattern = RX_FLOW;
  int          pattern_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  load_cell_adc_serial_reader dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lcadc_reading_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .results_due (results_due),
    .measuring   (measuring)
  );

  // receiver backpressure, pattern changes when its random countdown runs out
  always @(posedge clk) begin
    if (pattern_left == 0) begin
      rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
      pattern_left <= $urandom_range(16, 96);
    end else begin
      pattern_left <= pattern_left - 1;
    end
    case (rx_pattern)
      RX_FLOW:         out_ready <= 1'b1;
      RX_COIN:         out_ready <= 1'($urandom_range(0, 1));
      RX_EVERY_FOURTH: out_ready <= (pattern_left % 4 == 0);
      default:         out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("load_cell_adc_serial_reader_test: done, errors");
      $finish;
    end
  end

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic push_beat(input logic cmd, input logic pin);
    int       gap;
    in_item_t beat;
    if ($urandom_range(0, 199) == 0) wait_quiet();
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    beat.cmd = cmd;
    beat.data_level = pin;
    in_data <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [1:0] gain, input logic fast,
                              input logic [7:0] avg, input logic [23:0] tmo,
                              input logic [7:0] half, input logic [4:0] sha,
                              input logic [4:0] shb);
    wait_quiet();
    write_reg(REG_GAIN_MODE, 24'(gain));
    write_reg(REG_FAST_RATE, 24'(fast));
    write_reg(REG_AVERAGE_COUNT, 24'(avg));
    write_reg(REG_TIMEOUT_TICKS, tmo);
    write_reg(REG_HALF_PERIOD, 24'(half));
    write_reg(REG_SHIFT_A, 24'(sha));
    write_reg(REG_SHIFT_B, 24'(shb));
    cfg_valid <= 1'b0;
  endtask

  // ticks (with random starts early on) until the measurement in flight is over, data pin shaped by style
  task automatic finish_measurement(input pin_style_t style);
    int   run_left;
    int   sent;
    logic level;
    logic pin;
    logic cmd;
    run_left = 0;
    sent = 0;
    level = 1'b0;
    do begin
      case (style)
        PIN_COIN:        pin = 1'($urandom_range(0, 1));
        PIN_MOSTLY_HIGH: pin = ($urandom_range(0, 9) != 0);
        PIN_RUNS: begin
          if (run_left == 0) begin
            level = ~level;
            run_left = $urandom_range(1, 30);
          end
          run_left--;
          pin = level;
        end
        default:         pin = 1'b0;
      endcase
      cmd = (sent < BUSY_START_WINDOW && $urandom_range(0, 9) == 0) ? CMD_START : CMD_TICK;
      push_beat(cmd, pin);
      sent++;
    end while (measuring);
  endtask

  task automatic run_measurement(input pin_style_t style);
    push_beat(CMD_START, 1'($urandom_range(0, 1)));
    finish_measurement(style);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: idle ticks, a start, then starts while busy
    push_beat(CMD_TICK, 1'b0);
    push_beat(CMD_TICK, 1'b1);
    push_beat(CMD_START, 1'b1);
    push_beat(CMD_START, 1'b0);
    push_beat(CMD_TICK, 1'b1);
    push_beat(CMD_START, 1'b1);
    finish_measurement(PIN_COIN);

    // zero registers act as one
    program_regs(GAIN_A_128, 1'b1, 8'd0, 24'd0, 8'd0, 5'd0, 5'd23);
    run_measurement(PIN_COIN);
    run_measurement(PIN_MOSTLY_HIGH);
    run_measurement(PIN_HELD_LOW);

    program_regs(GAIN_A_64, 1'b0, 8'd2, 24'd5, 8'd1, 5'd23, 5'd0);
    run_measurement(PIN_RUNS);
    run_measurement(PIN_MOSTLY_HIGH);

    // longest timeout, full shifts
    program_regs(GAIN_B_32, 1'b1, 8'd2, 24'hFFFFFF, 8'd1, 5'd31, 5'd31);
    run_measurement(PIN_RUNS);

    // unused gain code with a slower serial clock
    program_regs(GAIN_UNUSED, 1'b0, 8'd1, 24'd3, 8'd3, 5'd12, 5'd5);
    run_measurement(PIN_COIN);

    while (beats_sent < ITEM_BUDGET) begin
      program_regs(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 2))
                                               : 8'($urandom_range(0, 6)),
                   ($urandom_range(0, 3) != 0) ? 24'($urandom_range(0, 12))
                                               : 24'($urandom_range(0, 24'hFFFFFF)),
                   ($urandom_range(0, 2) != 0) ? 8'd1 : 8'($urandom_range(0, 4)),
                   ($urandom_range(0, 7) != 0) ? 5'($urandom_range(0, 23))
                                               : 5'($urandom_range(24, 31)),
                   ($urandom_range(0, 7) != 0) ? 5'($urandom_range(0, 23))
                                               : 5'($urandom_range(24, 31)));
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 3)) push_beat(CMD_TICK, 1'($urandom_range(0, 1)));
        run_measurement(pin_style_t'($urandom_range(0, 3)));
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("load_cell_adc_serial_reader_test: done, clean");
    else
      $display("load_cell_adc_serial_reader_test: done, errors");
    $finish;
  end

endmodule
